// File: design/tch_pkg.sv
`timescale 1ns / 1ps

package tch_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TAB_LEN = 24;

    // cordic x/y path, angle path and multiplier widths
    localparam int XW = 38;
    localparam int ZW = 34;
    localparam int PW = 34;
    localparam int AW = 2 * PW;

    localparam logic signed [ZW-1:0] ANG_PI = 34'sd2147483648;
    localparam logic signed [ZW-1:0] ANG_HALF_PI = 34'sd1073741824;
    localparam logic signed [XW-1:0] INV_GAIN = 38'sd652032874;

    localparam logic OPC_QUAT = 1'b0;
    localparam logic OPC_FIELD = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] field_x;
        logic signed [15:0] field_y;
        logic signed [15:0] field_z;
    } t_in;

    typedef struct packed {
        logic signed [15:0] heading;
        logic signed [15:0] heading_sin_half;
        logic signed [15:0] heading_cos_half;
        logic               heading_fresh;
    } t_out;

    typedef struct packed {
        logic               compute;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        logic signed [15:0] fz;
    } t_job;

    typedef enum logic {
        CM_VEC,
        CM_ROT
    } t_cmode;

    typedef struct packed {
        t_cmode             mode;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_creq;

    typedef struct packed {
        logic               done;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cres;

    typedef enum logic [4:0] {
        S_IDLE,
        S_QPROD,
        S_ROLL_GO,
        S_ROLL_W,
        S_GAIN,
        S_PITCH_GO,
        S_PITCH_W,
        S_RROT_GO,
        S_RROT_W,
        S_PROT_GO,
        S_PROT_W,
        S_FPROD,
        S_YAW_GO,
        S_YAW_W,
        S_HALF_GO,
        S_HALF_W,
        S_OUT
    } t_state;

    function automatic logic [31:0] atan_tab(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// File: design/tilt_compensated_heading.sv
`timescale 1ns / 1ps
// an item that completes a heading makes six passes through the one shared iterative
// cordic unit plus 15 multiplies; an item that completes no heading skips them
// the back end takes one item at a time; a 2-entry queue lets the front keep accepting until full
// reset: synchronous active low; clears pending flags, queue and heading to zero, no result valid

module tilt_compensated_heading #(
    parameter int CORDIC_STEPS = tch_pkg::CORDIC_STEPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tch_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tch_pkg::t_out o_out_data
);

    logic          w_push;
    logic          w_full;
    logic          w_pop;
    logic          w_empty;
    tch_pkg::t_job w_job_in;
    tch_pkg::t_job w_job_out;

    tch_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_in_valid),
        .o_ready(o_in_ready),
        .i_data (i_in_data),
        .o_push (w_push),
        .o_job  (w_job_in),
        .i_full (w_full)
    );

    tch_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_job  (w_job_in),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_job  (w_job_out),
        .o_empty(w_empty)
    );

    tch_back #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(w_empty),
        .i_job  (w_job_out),
        .o_pop  (w_pop),
        .o_valid(o_out_valid),
        .i_ready(i_out_ready),
        .o_data (o_out_data)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_empty))
        else $error("queue pop while empty");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

// File: design/tch_queue.sv
`timescale 1ns / 1ps

module tch_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tch_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output tch_pkg::t_job o_job,
    output logic          o_empty
);

    tch_pkg::t_job r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// File: design/tch_front.sv
`timescale 1ns / 1ps

module tch_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  tch_pkg::t_in  i_data,
    output logic          o_push,
    output tch_pkg::t_job o_job,
    input  logic          i_full
);

    logic signed [15:0] r_qx, r_qy, r_qz, r_qw;
    logic signed [15:0] r_fx, r_fy, r_fz;
    logic               r_q_pend;
    logic               r_f_pend;
    logic               w_is_quat;
    logic               n_q_pend;
    logic               n_f_pend;

    assign o_ready   = !i_full;
    assign o_push    = i_valid && !i_full;
    assign w_is_quat = (i_data.opcode == tch_pkg::OPC_QUAT);
    assign n_q_pend  = r_q_pend || w_is_quat;
    assign n_f_pend  = r_f_pend || !w_is_quat;

    // job carries a snapshot of the newest samples
    always_comb begin
        o_job.compute = n_q_pend && n_f_pend;
        o_job.qx = w_is_quat ? i_data.quat_x : r_qx;
        o_job.qy = w_is_quat ? i_data.quat_y : r_qy;
        o_job.qz = w_is_quat ? i_data.quat_z : r_qz;
        o_job.qw = w_is_quat ? i_data.quat_w : r_qw;
        o_job.fx = w_is_quat ? r_fx : i_data.field_x;
        o_job.fy = w_is_quat ? r_fy : i_data.field_y;
        o_job.fz = w_is_quat ? r_fz : i_data.field_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_pend <= 1'b0;
            r_f_pend <= 1'b0;
        end else if (o_push) begin
            r_q_pend <= o_job.compute ? 1'b0 : n_q_pend;
            r_f_pend <= o_job.compute ? 1'b0 : n_f_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push) begin
            r_qx <= o_job.qx;
            r_qy <= o_job.qy;
            r_qz <= o_job.qz;
            r_qw <= o_job.qw;
            r_fx <= o_job.fx;
            r_fy <= o_job.fy;
            r_fz <= o_job.fz;
        end
    end

endmodule

// File: design/tch_cordic.sv
`timescale 1ns / 1ps

module tch_cordic #(
    parameter int CORDIC_STEPS = tch_pkg::CORDIC_STEPS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  tch_pkg::t_creq i_req,
    output tch_pkg::t_cres o_res
);

    localparam int XW = tch_pkg::XW;
    localparam int ZW = tch_pkg::ZW;
    localparam int IW = $clog2(CORDIC_STEPS);

    logic                 r_busy;
    logic                 r_done;
    logic [IW-1:0]        r_i;
    tch_pkg::t_cmode      r_mode;
    logic                 r_neg;
    logic signed [XW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic signed [XW-1:0] r_rx, r_ry;
    logic signed [ZW-1:0] r_rz;

    logic [4:0]           w_idx;
    logic signed [XW-1:0] w_shx, w_shy;
    logic signed [ZW-1:0] w_tab;
    logic                 w_up;
    logic signed [XW-1:0] w_nx, w_ny;
    logic signed [ZW-1:0] w_nz;
    logic signed [ZW-1:0] w_z32;
    logic                 w_last;

    assign w_idx  = 5'(r_i);
    assign w_shx  = r_y >>> w_idx;
    assign w_shy  = r_x >>> w_idx;
    assign w_tab  = ZW'(tch_pkg::atan_tab(w_idx));
    assign w_up   = (r_mode == tch_pkg::CM_VEC) ? (r_y >= 0) : (r_z < 0);
    assign w_nx   = w_up ? (r_x + w_shx) : (r_x - w_shx);
    assign w_ny   = w_up ? (r_y - w_shy) : (r_y + w_shy);
    assign w_nz   = w_up ? (r_z + w_tab) : (r_z - w_tab);
    assign w_last = (r_i == IW'(CORDIC_STEPS - 1));
    // rotation angle wraps to one turn
    assign w_z32  = ZW'($signed(i_req.z[31:0]));

    assign o_res.done = r_done;
    assign o_res.x    = r_rx;
    assign o_res.y    = r_ry;
    assign o_res.z    = r_rz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_req.mode == tch_pkg::CM_VEC && i_req.x == 0 && i_req.y == 0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy && w_last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_i    <= '0;
            r_mode <= i_req.mode;
            r_neg  <= 1'b0;
            if (i_req.mode == tch_pkg::CM_VEC) begin
                r_rx <= '0;
                r_ry <= '0;
                r_rz <= '0;
                if (i_req.x < 0) begin
                    if (i_req.y >= 0) begin
                        r_x <= i_req.y;
                        r_y <= -i_req.x;
                        r_z <= tch_pkg::ANG_HALF_PI;
                    end else begin
                        r_x <= -i_req.y;
                        r_y <= i_req.x;
                        r_z <= -tch_pkg::ANG_HALF_PI;
                    end
                end else begin
                    r_x <= i_req.x;
                    r_y <= i_req.y;
                    r_z <= '0;
                end
            end else begin
                r_x <= tch_pkg::INV_GAIN;
                r_y <= '0;
                if (w_z32 > tch_pkg::ANG_HALF_PI) begin
                    r_z   <= w_z32 - tch_pkg::ANG_PI;
                    r_neg <= 1'b1;
                end else if (w_z32 < -tch_pkg::ANG_HALF_PI) begin
                    r_z   <= w_z32 + tch_pkg::ANG_PI;
                    r_neg <= 1'b1;
                end else begin
                    r_z <= w_z32;
                end
            end
        end else if (r_busy) begin
            r_i <= r_i + IW'(1);
            r_x <= w_nx;
            r_y <= w_ny;
            r_z <= w_nz;
            if (w_last) begin
                r_rx <= r_neg ? -w_nx : w_nx;
                r_ry <= r_neg ? -w_ny : w_ny;
                r_rz <= w_nz;
            end
        end
    end

endmodule

// File: design/tch_back.sv
`timescale 1ns / 1ps

module tch_back #(
    parameter int CORDIC_STEPS = tch_pkg::CORDIC_STEPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  tch_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output tch_pkg::t_out o_data
);

    localparam int XW = tch_pkg::XW;
    localparam int ZW = tch_pkg::ZW;
    localparam int PW = tch_pkg::PW;
    localparam int AW = tch_pkg::AW;

    // multiply schedule
    localparam logic [3:0] OP_XZ    = 4'd0;
    localparam logic [3:0] OP_WY    = 4'd1;
    localparam logic [3:0] OP_YZ    = 4'd2;
    localparam logic [3:0] OP_WX    = 4'd3;
    localparam logic [3:0] OP_WW    = 4'd4;
    localparam logic [3:0] OP_ZZ    = 4'd5;
    localparam logic [3:0] OP_XX    = 4'd6;
    localparam logic [3:0] OP_YY    = 4'd7;
    localparam logic [3:0] OP_GAIN  = 4'd8;
    localparam logic [3:0] OP_CRMY  = 4'd9;
    localparam logic [3:0] OP_SRMZ  = 4'd10;
    localparam logic [3:0] OP_CRMZ  = 4'd11;
    localparam logic [3:0] OP_SRMY  = 4'd12;
    localparam logic [3:0] OP_CPMX  = 4'd13;
    localparam logic [3:0] OP_SPV2  = 4'd14;
    localparam logic [3:0] OP_DRAIN = 4'd15;

    tch_pkg::t_state      r_state, n_state;
    tch_pkg::t_job        r_job;
    logic [3:0]           r_k;
    logic [3:0]           r_pk;
    logic                 r_pv;
    logic signed [AW-1:0] r_prod;
    logic signed [AW-1:0] r_acc_a, r_acc_b, r_acc_c;
    logic signed [AW-1:0] r_t1, r_t2, r_t3;
    logic signed [ZW-1:0] r_roll, r_pitch;
    logic signed [XW-1:0] r_mag;
    logic signed [PW-1:0] r_cr, r_sr, r_cp, r_sp;
    logic signed [15:0]   r_head, r_sinh, r_cosh;
    logic                 r_fresh;
    logic                 r_ovalid;
    tch_pkg::t_out        r_odata;

    logic                 w_issue;
    logic                 w_cstart;
    logic                 w_load;
    tch_pkg::t_creq       w_creq;
    tch_pkg::t_cres       w_cres;
    logic signed [PW-1:0] w_ma, w_mb;
    logic signed [ZW-1:0] w_yaw_sum;

    function automatic logic signed [15:0] to_q14(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] r;
        logic signed [15:0]   q;
        r = (v + XW'(32768)) >>> 16;
        if (r > XW'(16384)) begin
            q = 16'sd16384;
        end else if (r < -XW'(16384)) begin
            q = -16'sd16384;
        end else begin
            q = 16'(r);
        end
        return q;
    endfunction

    tch_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_cstart),
        .i_req  (w_creq),
        .o_res  (w_cres)
    );

    assign o_valid   = r_ovalid;
    assign o_data    = r_odata;
    assign w_yaw_sum = -w_cres.z + ZW'(32768);

    always_comb begin
        case (r_k)
            OP_XZ:   begin w_ma = PW'(r_job.qx); w_mb = PW'(r_job.qz); end
            OP_WY:   begin w_ma = PW'(r_job.qw); w_mb = PW'(r_job.qy); end
            OP_YZ:   begin w_ma = PW'(r_job.qy); w_mb = PW'(r_job.qz); end
            OP_WX:   begin w_ma = PW'(r_job.qw); w_mb = PW'(r_job.qx); end
            OP_WW:   begin w_ma = PW'(r_job.qw); w_mb = PW'(r_job.qw); end
            OP_ZZ:   begin w_ma = PW'(r_job.qz); w_mb = PW'(r_job.qz); end
            OP_XX:   begin w_ma = PW'(r_job.qx); w_mb = PW'(r_job.qx); end
            OP_YY:   begin w_ma = PW'(r_job.qy); w_mb = PW'(r_job.qy); end
            OP_GAIN: begin w_ma = PW'(r_mag >>> 4); w_mb = PW'(tch_pkg::INV_GAIN); end
            OP_CRMY: begin w_ma = r_cr; w_mb = PW'(r_job.fy); end
            OP_SRMZ: begin w_ma = r_sr; w_mb = PW'(r_job.fz); end
            OP_CRMZ: begin w_ma = r_cr; w_mb = PW'(r_job.fz); end
            OP_SRMY: begin w_ma = r_sr; w_mb = PW'(r_job.fy); end
            OP_CPMX: begin w_ma = r_cp; w_mb = PW'(r_job.fx); end
            OP_SPV2: begin w_ma = r_sp; w_mb = PW'(r_t2 >>> 15); end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        o_pop       = 1'b0;
        w_issue     = 1'b0;
        w_cstart    = 1'b0;
        w_load      = 1'b0;
        w_creq.mode = tch_pkg::CM_VEC;
        w_creq.x    = '0;
        w_creq.y    = '0;
        w_creq.z    = '0;
        case (r_state)
            tch_pkg::S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = i_job.compute ? tch_pkg::S_QPROD : tch_pkg::S_OUT;
                end
            end
            tch_pkg::S_QPROD: begin
                if (r_k == OP_GAIN) begin
                    n_state = tch_pkg::S_ROLL_GO;
                end else begin
                    w_issue = 1'b1;
                end
            end
            tch_pkg::S_ROLL_GO: begin
                w_cstart = 1'b1;
                w_creq.x = XW'(r_acc_c);
                w_creq.y = XW'(r_acc_b <<< 1);
                n_state  = tch_pkg::S_ROLL_W;
            end
            tch_pkg::S_ROLL_W: begin
                if (w_cres.done) begin
                    n_state = tch_pkg::S_GAIN;
                end
            end
            tch_pkg::S_GAIN: begin
                w_issue = 1'b1;
                n_state = tch_pkg::S_PITCH_GO;
            end
            tch_pkg::S_PITCH_GO: begin
                w_cstart = 1'b1;
                w_creq.x = XW'(r_prod >>> 30);
                // asr(2a, 4) is a floor divide of a by 8
                w_creq.y = XW'(r_acc_a >>> 3);
                n_state  = tch_pkg::S_PITCH_W;
            end
            tch_pkg::S_PITCH_W: begin
                if (w_cres.done) begin
                    n_state = tch_pkg::S_RROT_GO;
                end
            end
            tch_pkg::S_RROT_GO: begin
                w_cstart    = 1'b1;
                w_creq.mode = tch_pkg::CM_ROT;
                w_creq.z    = r_roll;
                n_state     = tch_pkg::S_RROT_W;
            end
            tch_pkg::S_RROT_W: begin
                if (w_cres.done) begin
                    n_state = tch_pkg::S_PROT_GO;
                end
            end
            tch_pkg::S_PROT_GO: begin
                w_cstart    = 1'b1;
                w_creq.mode = tch_pkg::CM_ROT;
                w_creq.z    = r_pitch;
                n_state     = tch_pkg::S_PROT_W;
            end
            tch_pkg::S_PROT_W: begin
                if (w_cres.done) begin
                    n_state = tch_pkg::S_FPROD;
                end
            end
            tch_pkg::S_FPROD: begin
                if (r_k == OP_DRAIN) begin
                    n_state = tch_pkg::S_YAW_GO;
                end else begin
                    w_issue = 1'b1;
                end
            end
            tch_pkg::S_YAW_GO: begin
                w_cstart = 1'b1;
                w_creq.x = XW'(r_t1 >>> 15);
                w_creq.y = -XW'(r_t3 >>> 30);
                n_state  = tch_pkg::S_YAW_W;
            end
            tch_pkg::S_YAW_W: begin
                if (w_cres.done) begin
                    n_state = tch_pkg::S_HALF_GO;
                end
            end
            tch_pkg::S_HALF_GO: begin
                w_cstart    = 1'b1;
                w_creq.mode = tch_pkg::CM_ROT;
                w_creq.z    = ZW'(r_head) <<< 15;
                n_state     = tch_pkg::S_HALF_W;
            end
            tch_pkg::S_HALF_W: begin
                if (w_cres.done) begin
                    n_state = tch_pkg::S_OUT;
                end
            end
            tch_pkg::S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    w_load  = 1'b1;
                    n_state = tch_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tch_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tch_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_pv     <= 1'b0;
            r_head   <= '0;
            r_sinh   <= '0;
            r_cosh   <= '0;
        end else begin
            r_state <= n_state;
            r_pv    <= w_issue;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (r_state == tch_pkg::S_YAW_W && w_cres.done) begin
                r_head <= w_yaw_sum[31:16];
            end
            if (r_state == tch_pkg::S_HALF_W && w_cres.done) begin
                r_sinh <= to_q14(w_cres.y);
                r_cosh <= to_q14(w_cres.x);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job   <= i_job;
            r_fresh <= i_job.compute;
            r_k     <= OP_XZ;
        end else if (w_issue) begin
            r_k <= r_k + 4'd1;
        end
        if (w_issue) begin
            r_prod <= w_ma * w_mb;
            r_pk   <= r_k;
        end
        // accumulate the product issued in the previous cycle
        if (r_pv) begin
            case (r_pk)
                OP_XZ:   r_acc_a <= r_prod;
                OP_WY:   r_acc_a <= r_acc_a - r_prod;
                OP_YZ:   r_acc_b <= r_prod;
                OP_WX:   r_acc_b <= r_acc_b + r_prod;
                OP_WW:   r_acc_c <= r_prod;
                OP_ZZ:   r_acc_c <= r_acc_c + r_prod;
                OP_XX:   r_acc_c <= r_acc_c - r_prod;
                OP_YY:   r_acc_c <= r_acc_c - r_prod;
                OP_CRMY: r_t1 <= r_prod;
                OP_SRMZ: r_t1 <= r_t1 + r_prod;
                OP_CRMZ: r_t2 <= r_prod;
                OP_SRMY: r_t2 <= r_t2 - r_prod;
                OP_CPMX: r_t3 <= r_prod <<< 15;
                OP_SPV2: r_t3 <= r_t3 - r_prod;
                default: ;
            endcase
        end
        if (w_cres.done) begin
            case (r_state)
                tch_pkg::S_ROLL_W: begin
                    r_roll <= w_cres.z;
                    r_mag  <= w_cres.x;
                end
                tch_pkg::S_PITCH_W: r_pitch <= -w_cres.z;
                tch_pkg::S_RROT_W: begin
                    r_cr <= PW'(w_cres.x);
                    r_sr <= PW'(w_cres.y);
                end
                tch_pkg::S_PROT_W: begin
                    r_cp <= PW'(w_cres.x);
                    r_sp <= PW'(w_cres.y);
                end
                default: ;
            endcase
        end
        if (w_load) begin
            r_odata.heading          <= r_head;
            r_odata.heading_sin_half <= r_sinh;
            r_odata.heading_cos_half <= r_cosh;
            r_odata.heading_fresh    <= r_fresh;
        end
    end

endmodule
